// File: hdl/bpd_pkg.sv
`default_nettype none
package bpd_pkg;

    localparam int BAR_SLOTS = 6;

    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_IO   = 2'd1;
    localparam logic [1:0] KIND_MEM  = 2'd2;

    localparam logic [1:0] MEM_TYPE_32  = 2'd0;
    localparam logic [1:0] MEM_TYPE_1M  = 2'd1;
    localparam logic [1:0] MEM_TYPE_64  = 2'd2;
    localparam logic [1:0] MEM_TYPE_RSV = 2'd3;

    localparam logic [31:0] U32_ALL          = 32'hFFFF_FFFF;
    localparam logic [31:0] IO_ADDR_MASK     = 32'hFFFF_FFFC;
    localparam logic [31:0] MEM_ADDR_MASK    = 32'hFFFF_FFF0;
    localparam logic [31:0] MEM_1M_ADDR_MASK = 32'h000F_FFF0;
    localparam logic [31:0] MEM_1M_HIGH_ONES = 32'hFFF0_0000;
    localparam logic [3:0]  MEM_LOW_ATTR     = 4'hF;
    localparam logic [3:0]  IO_LOW_ATTR      = 4'h3;
    localparam logic [63:0] IO_MIN_SIZE      = 64'd4;
    localparam logic [63:0] MEM_MIN_SIZE     = 64'd16;

    typedef struct packed {
        logic [2:0]  bar_index;
        logic [31:0] orig_low;
        logic [31:0] probe_low;
        logic [31:0] orig_high;
        logic [31:0] probe_high;
    } bar_probe_in_t;

    typedef struct packed {
        logic        status;
        logic [1:0]  bar_kind;
        logic        is_wide;
        logic [63:0] base_address;
        logic [63:0] region_size;
        logic [3:0]  attr_flags;
    } bar_probe_out_t;

    typedef struct packed {
        logic        bad;
        logic        unimpl;
        logic        is_io;
        logic        wide;
        logic [63:0] pb;
        logic [63:0] mask;
        logic [3:0]  attrs;
    } bpd_dec_t;

    typedef struct packed {
        logic        bad;
        logic        unimpl;
        logic        is_io;
        logic        wide;
        logic [63:0] pb;
        logic [63:0] size;
        logic [3:0]  attrs;
    } bpd_size_t;

    typedef struct packed {
        logic        bad;
        logic        unimpl;
        logic        is_io;
        logic        wide;
        logic        ge_min;
        logic        pb_nz;
        logic [63:0] pb;
        logic [63:0] size;
        logic [63:0] size_m1;
        logic [3:0]  attrs;
    } bpd_chk_t;

endpackage
`default_nettype wire

// File: hdl/bpd_decode.sv
`default_nettype none
module bpd_decode
    import bpd_pkg::*;
#(
    parameter int NUM_BARS = BAR_SLOTS
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    input  wire bar_probe_in_t req,
    output logic               out_valid,
    output bpd_dec_t           dec
);

    logic          valid_reg;
    bpd_dec_t      dec_reg;
    bpd_dec_t      dec_next;
    logic [31:0]   attrs_w;
    logic [1:0]    mem_sel;

    always_comb
    begin
        attrs_w  = (req.orig_low != 32'd0) ? req.orig_low : req.probe_low;
        mem_sel  = attrs_w[2:1];
        dec_next = '0;
        dec_next.attrs = attrs_w[3:0];
        dec_next.is_io = attrs_w[0];
        if (req.bar_index >= 3'(NUM_BARS))
        begin
            dec_next.bad = 1'b1;
        end
        else if (req.orig_low == U32_ALL || req.probe_low == 32'd0)
        begin
            dec_next.unimpl = 1'b1;
        end
        else if (attrs_w[0])
        begin
            dec_next.pb   = {32'd0, req.orig_low & IO_ADDR_MASK};
            dec_next.mask = {U32_ALL, req.probe_low & IO_ADDR_MASK};
        end
        else
        begin
            unique case (mem_sel)
                MEM_TYPE_64:
                begin
                    if (req.bar_index == 3'(NUM_BARS - 1))
                    begin
                        dec_next.bad = 1'b1;
                    end
                    else
                    begin
                        dec_next.wide = 1'b1;
                        dec_next.pb   = {req.orig_high, req.orig_low & MEM_ADDR_MASK};
                        dec_next.mask = {req.probe_high, req.probe_low & MEM_ADDR_MASK};
                    end
                end
                MEM_TYPE_1M:
                begin
                    dec_next.pb   = {32'd0, req.orig_low & MEM_1M_ADDR_MASK};
                    dec_next.mask = {U32_ALL,
                                     (req.probe_low & MEM_1M_ADDR_MASK) | MEM_1M_HIGH_ONES};
                end
                MEM_TYPE_32:
                begin
                    dec_next.pb   = {32'd0, req.orig_low & MEM_ADDR_MASK};
                    dec_next.mask = {U32_ALL, req.probe_low & MEM_ADDR_MASK};
                end
                MEM_TYPE_RSV:
                begin
                    dec_next.bad = 1'b1;
                end
                default:
                begin
                    dec_next.bad = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        dec_reg <= dec_next;
    end

    assign out_valid = valid_reg;
    assign dec       = dec_reg;

endmodule
`default_nettype wire

// File: hdl/bpd_size.sv
`default_nettype none
module bpd_size
    import bpd_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    input  wire bpd_dec_t dec,
    output logic          out_valid,
    output bpd_size_t     sz
);

    logic      valid_reg;
    bpd_size_t sz_reg;
    bpd_size_t sz_next;

    always_comb
    begin
        sz_next.bad    = dec.bad;
        sz_next.unimpl = dec.unimpl;
        sz_next.is_io  = dec.is_io;
        sz_next.wide   = dec.wide;
        sz_next.pb     = dec.pb;
        sz_next.attrs  = dec.attrs;
        if (dec.wide)
        begin
            sz_next.size = ~dec.mask + 64'd1;
        end
        else
        begin
            sz_next.size = {32'd0, ~dec.mask[31:0] + 32'd1};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        sz_reg <= sz_next;
    end

    assign out_valid = valid_reg;
    assign sz        = sz_reg;

endmodule
`default_nettype wire

// File: hdl/bpd_check.sv
`default_nettype none
module bpd_check
    import bpd_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    input  wire bpd_size_t sz,
    output logic           out_valid,
    output bar_probe_out_t rsp
);

    logic           chk_valid_reg;
    bpd_chk_t       chk_reg;
    bpd_chk_t       chk_next;
    logic           done_reg;
    bar_probe_out_t rsp_reg;
    bar_probe_out_t rsp_next;
    logic           pow2;
    logic           align_ok;
    logic           size_ok;

    always_comb
    begin
        chk_next.bad     = sz.bad;
        chk_next.unimpl  = sz.unimpl;
        chk_next.is_io   = sz.is_io;
        chk_next.wide    = sz.wide;
        chk_next.pb      = sz.pb;
        chk_next.size    = sz.size;
        chk_next.attrs   = sz.attrs;
        chk_next.size_m1 = sz.size - 64'd1;
        chk_next.ge_min  = sz.size >= (sz.is_io ? IO_MIN_SIZE : MEM_MIN_SIZE);
        chk_next.pb_nz   = sz.pb != 64'd0;
    end

    always_comb
    begin
        pow2     = (chk_reg.size & chk_reg.size_m1) == 64'd0;
        align_ok = (chk_reg.pb & chk_reg.size_m1) == 64'd0;
        size_ok  = chk_reg.ge_min && pow2 && align_ok;
        rsp_next = '0;
        priority if (chk_reg.bad)
        begin
            rsp_next.status = 1'b1;
        end
        else if (chk_reg.unimpl)
        begin
            rsp_next.status = 1'b0;
        end
        else
        begin
            rsp_next.is_wide = chk_reg.wide;
            rsp_next.status  = !size_ok;
            if (size_ok && chk_reg.pb_nz)
            begin
                rsp_next.bar_kind     = chk_reg.is_io ? KIND_IO : KIND_MEM;
                rsp_next.base_address = chk_reg.pb;
                rsp_next.region_size  = chk_reg.size;
                rsp_next.attr_flags   = chk_reg.attrs
                                        & (chk_reg.is_io ? IO_LOW_ATTR : MEM_LOW_ATTR);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chk_valid_reg <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            chk_valid_reg <= in_valid;
            done_reg      <= chk_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        chk_reg <= chk_next;
        rsp_reg <= rsp_next;
    end

    assign out_valid = done_reg;
    assign rsp       = rsp_reg;

endmodule
`default_nettype wire

// File: hdl/pci_bar_probe_decode_unit.sv
// Once start is taken, the result strobes on done after the item has passed every stage.
// Throughput: one item per cycle; four register stages (decode, size,
// check, result) run independently, so busy stays low.
// The receiver cannot stall; each result shows for exactly one cycle.
// Reset (rst_n, async, active low) clears all stage valid bits; no result
// follows reset until a new item is taken.
`default_nettype none
module pci_bar_probe_decode_unit
    import bpd_pkg::*;
#(
    parameter int NUM_BARS = BAR_SLOTS
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire bar_probe_in_t req,
    output logic               done,
    output bar_probe_out_t     rsp
);

    logic      dec_valid;
    bpd_dec_t  dec;
    logic      sz_valid;
    bpd_size_t sz;

    assign busy = 1'b0;

    bpd_decode
    #(
        .NUM_BARS  (NUM_BARS)
    )
    u_decode
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start && !busy),
        .req       (req),
        .out_valid (dec_valid),
        .dec       (dec)
    );

    bpd_size u_size
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (dec_valid),
        .dec       (dec),
        .out_valid (sz_valid),
        .sz        (sz)
    );

    bpd_check u_check
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sz_valid),
        .sz        (sz),
        .out_valid (done),
        .rsp       (rsp)
    );

endmodule
`default_nettype wire

// File: sim/bar_decode_checker.sv
module bar_decode_checker
    import bpd_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic           busy,
    input  bar_probe_in_t  req,
    input  logic           done,
    input  bar_probe_out_t rsp,
    output int             errors,
    output int             pending
);
    timeunit 1ns;
    timeprecision 1ps;

    bar_probe_out_t expected_decodes[$];
    bar_probe_out_t want;
    int             mismatches = 0;

    function automatic logic [63:0] size_of_mask32(logic [31:0] mask);
        logic [31:0] neg;
        neg = ~mask + 32'd1;
        return (mask == 32'd0) ? 64'd0 : {32'd0, neg};
    endfunction

    function automatic logic [63:0] size_of_mask64(logic [63:0] mask);
        return (mask == 64'd0) ? 64'd0 : ~mask + 64'd1;
    endfunction

    function automatic bit size_good(logic [63:0] sz, logic [63:0] min_sz);
        return sz >= min_sz && (sz & (sz - 64'd1)) == 64'd0;
    endfunction

    function automatic bar_probe_out_t decode_bar(bar_probe_in_t it);
        bar_probe_out_t r;
        logic [31:0]    attrs;
        logic [63:0]    pb;
        logic [63:0]    sz;
        bit             bad;
        r = '0;
        pb = '0;
        sz = '0;
        bad = 1'b0;
        if (it.bar_index >= BAR_SLOTS)
        begin
            r.status = 1'b1;
        end
        else if (it.orig_low != U32_ALL && it.probe_low != 32'd0)
        begin
            attrs = (it.orig_low != 32'd0) ? it.orig_low : it.probe_low;
            if (attrs[0])
            begin
                pb = {32'd0, it.orig_low & IO_ADDR_MASK};
                sz = size_of_mask32(it.probe_low & IO_ADDR_MASK);
                if (!size_good(sz, IO_MIN_SIZE) || (pb & (sz - 64'd1)) != 64'd0)
                begin
                    r.status = 1'b1;
                end
                else if (pb != 64'd0)
                begin
                    r.bar_kind = KIND_IO;
                    r.base_address = pb;
                    r.region_size = sz;
                    r.attr_flags = attrs[3:0] & IO_LOW_ATTR;
                end
            end
            else
            begin
                case (attrs[2:1])
                    MEM_TYPE_64:
                    begin
                        if (it.bar_index == BAR_SLOTS - 1)
                        begin
                            bad = 1'b1;
                        end
                        else
                        begin
                            pb = {it.orig_high, it.orig_low & MEM_ADDR_MASK};
                            sz = size_of_mask64({it.probe_high, it.probe_low & MEM_ADDR_MASK});
                            r.is_wide = 1'b1;
                        end
                    end
                    MEM_TYPE_1M:
                    begin
                        pb = {32'd0, it.orig_low & MEM_1M_ADDR_MASK};
                        sz = size_of_mask32((it.probe_low & MEM_1M_ADDR_MASK)
                                            | MEM_1M_HIGH_ONES);
                    end
                    MEM_TYPE_32:
                    begin
                        pb = {32'd0, it.orig_low & MEM_ADDR_MASK};
                        sz = size_of_mask32(it.probe_low & MEM_ADDR_MASK);
                    end
                    default:
                    begin
                        bad = 1'b1;
                    end
                endcase
                if (bad || !size_good(sz, MEM_MIN_SIZE) || (pb & (sz - 64'd1)) != 64'd0)
                begin
                    r.status = 1'b1;
                end
                else if (pb != 64'd0)
                begin
                    r.bar_kind = KIND_MEM;
                    r.base_address = pb;
                    r.region_size = sz;
                    r.attr_flags = attrs[3:0] & MEM_LOW_ATTR;
                end
            end
        end
        return r;
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
            begin
                if (expected_decodes.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("%0t: result with nothing expected: %p", $realtime, rsp);
                    mismatches++;
                end
                else
                begin
                    want = expected_decodes.pop_front();
                    if (rsp.status !== want.status || rsp.bar_kind !== want.bar_kind
                        || rsp.is_wide !== want.is_wide
                        || rsp.base_address !== want.base_address
                        || rsp.region_size !== want.region_size
                        || rsp.attr_flags !== want.attr_flags)
                    begin
                        if (mismatches < 10)
                        begin
                            $display("%0t: decode mismatch", $realtime);
                            $display("  exp status %h kind %h wide %h base %h size %h attr %h",
                                     want.status, want.bar_kind, want.is_wide,
                                     want.base_address, want.region_size, want.attr_flags);
                            $display("  got status %h kind %h wide %h base %h size %h attr %h",
                                     rsp.status, rsp.bar_kind, rsp.is_wide,
                                     rsp.base_address, rsp.region_size, rsp.attr_flags);
                        end
                        mismatches++;
                    end
                end
            end
            if (start && !busy)
                expected_decodes.push_back(decode_bar(req));
        end
        errors <= mismatches;
        pending <= expected_decodes.size();
    end

endmodule

// File: sim/testbench.sv
module testbench
    import bpd_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 2000;

    logic           clk;
    logic           rst_n;
    logic           start;
    logic           busy;
    bar_probe_in_t  req;
    logic           done;
    bar_probe_out_t rsp;
    int             errors;
    int             pending;
    int unsigned    sender_idle_pct;
    int unsigned    phase_idle_pct[3] = '{37, 47, 0};

    pci_bar_probe_decode_unit dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .req   (req),
        .done  (done),
        .rsp   (rsp)
    );

    bar_decode_checker checker_i
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .req     (req),
        .done    (done),
        .rsp     (rsp),
        .errors  (errors),
        .pending (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic bar_probe_in_t make_bar();
        bar_probe_in_t it;
        int unsigned   shape;
        int unsigned   lg;
        logic [63:0]   sz;
        logic [63:0]   amask;
        logic [63:0]   base;
        logic [31:0]   attr;
        it.bar_index = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(6, 7))
                                                    : 3'($urandom_range(0, 5));
        it.orig_low = $urandom;
        it.probe_low = $urandom;
        it.orig_high = $urandom;
        it.probe_high = $urandom;
        attr = '0;
        shape = $urandom_range(0, 99);
        if (shape < 20)
        begin
            lg = $urandom_range(2, 31);
            sz = 64'd1 << lg;
            amask = ~(sz - 64'd1);
            attr = {30'd0, 1'($urandom_range(0, 1)), 1'b1};
            it.probe_low = (amask[31:0] & IO_ADDR_MASK) | attr;
            it.orig_low = ($urandom & amask[31:0] & IO_ADDR_MASK) | attr;
        end
        else if (shape < 40)
        begin
            lg = $urandom_range(4, 31);
            sz = 64'd1 << lg;
            amask = ~(sz - 64'd1);
            attr = {28'd0, 1'($urandom_range(0, 1)), MEM_TYPE_32, 1'b0};
            it.probe_low = (amask[31:0] & MEM_ADDR_MASK) | attr;
            it.orig_low = ($urandom & amask[31:0] & MEM_ADDR_MASK) | attr;
        end
        else if (shape < 52)
        begin
            lg = $urandom_range(4, 20);
            sz = 64'd1 << lg;
            amask = ~(sz - 64'd1);
            attr = {28'd0, 1'($urandom_range(0, 1)), MEM_TYPE_1M, 1'b0};
            it.probe_low = (amask[31:0] & MEM_1M_ADDR_MASK) | ($urandom & MEM_1M_HIGH_ONES)
                           | attr;
            it.orig_low = ($urandom & amask[31:0] & MEM_1M_ADDR_MASK)
                          | ($urandom & MEM_1M_HIGH_ONES) | attr;
        end
        else if (shape < 72)
        begin
            lg = $urandom_range(4, 63);
            sz = 64'd1 << lg;
            amask = ~(sz - 64'd1);
            attr = {28'd0, 1'($urandom_range(0, 1)), MEM_TYPE_64, 1'b0};
            base = {$urandom, $urandom} & amask & {U32_ALL, MEM_ADDR_MASK};
            it.bar_index = ($urandom_range(0, 9) == 0) ? 3'(BAR_SLOTS - 1)
                                                       : 3'($urandom_range(0, BAR_SLOTS - 2));
            it.probe_low = (amask[31:0] & MEM_ADDR_MASK) | attr;
            it.probe_high = amask[63:32];
            it.orig_low = base[31:0] | attr;
            it.orig_high = base[63:32];
        end
        else if (shape < 78)
        begin
            attr = {28'd0, 1'($urandom_range(0, 1)), MEM_TYPE_RSV, 1'b0};
            it.orig_low = (it.orig_low & MEM_ADDR_MASK) | attr;
            it.probe_low = (it.probe_low & MEM_ADDR_MASK) | attr;
        end
        else
        begin
            it.bar_index = 3'($urandom_range(0, 7));
        end
        if (shape < 72 && $urandom_range(0, 99) < 20)
        begin
            case ($urandom_range(0, 5))
                0:
                begin
                    it.orig_low = attr;
                    it.orig_high = '0;
                end
                1: it.orig_low = '0;
                2: it.probe_low = it.probe_low ^ (32'd1 << $urandom_range(4, 31));
                3: it.orig_low = it.orig_low ^ (32'd1 << $urandom_range(2, 31));
                4: it.orig_low = U32_ALL;
                default: it.probe_low = '0;
            endcase
        end
        return it;
    endfunction

    task automatic send_item(input bar_probe_in_t item);
        bar_probe_in_t junk;
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            junk = make_bar();
            start <= 1'b0;
            req <= junk;
            @(posedge clk);
        end
        req <= item;
        start <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic send_fields(input logic [2:0] idx, input logic [31:0] ol,
                               input logic [31:0] pl, input logic [31:0] oh,
                               input logic [31:0] ph);
        bar_probe_in_t it;
        it.bar_index = idx;
        it.orig_low = ol;
        it.probe_low = pl;
        it.orig_high = oh;
        it.probe_high = ph;
        send_item(it);
    endtask

    initial
    begin
        int unsigned idle_run;
        wait (rst_n === 1'b1);
        idle_run = 0;
        while (idle_run < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((start && !busy) || done)
                idle_run = 0;
            else
                idle_run++;
        end
        $display("testbench: errors");
        $finish;
    end

    initial
    begin
        rst_n <= 1'b0;
        start <= 1'b0;
        req <= '0;
        sender_idle_pct = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_fields(3'd7, 32'h1234_5671, 32'hFFFF_FF01, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_fields(3'd6, 32'h0000_1001, 32'hFFFF_FFFD, 32'h0, 32'h0);
        send_fields(3'd0, U32_ALL, 32'hFFFF_FFFD, 32'h0, 32'h0);
        send_fields(3'd1, 32'h0000_1001, 32'h0, 32'h0, 32'h0);
        send_fields(3'd2, 32'h0000_1001, 32'hFFFF_FFFD, 32'h0, 32'h0);
        send_fields(3'd3, 32'h0000_1003, 32'h0000_0001, 32'h0, 32'h0);
        send_fields(3'd4, 32'h0000_1081, 32'hFFFF_FF01, 32'h0, 32'h0);
        send_fields(3'd5, 32'h0001_0001, 32'hFFFF_0F01, 32'h0, 32'h0);
        send_fields(3'd0, 32'h0000_0000, 32'hFFFF_FF01, 32'h0, 32'h0);
        send_fields(3'd1, 32'h0000_0001, 32'hFFFF_FF01, 32'h0, 32'h0);
        send_fields(3'd2, 32'hFFFF_FFF8, 32'hFFFF_FFF8, 32'h0, 32'h0);
        send_fields(3'd3, 32'h8000_0000, 32'h8000_0000, 32'h0, 32'h0);
        send_fields(3'd4, 32'h0000_0000, 32'hFFF0_0000, 32'h0, 32'h0);
        send_fields(3'd5, 32'h0000_1000, 32'h0000_0008, 32'h0, 32'h0);
        send_fields(3'd0, 32'h000F_000A, 32'hFFFF_000A, 32'h0, 32'h0);
        send_fields(3'd1, 32'hFFF0_0002, 32'h0000_0002, 32'h0, 32'h0);
        send_fields(3'd0, 32'h0000_000C, 32'h0000_000C, 32'h0000_0001, 32'hFFFF_FFFF);
        send_fields(3'd5, 32'h0000_000C, 32'h0000_000C, 32'h0000_0001, 32'hFFFF_FFFF);
        send_fields(3'd2, 32'h0000_1004, 32'h0000_0004, 32'h0000_0000, 32'h0000_0000);
        send_fields(3'd3, 32'h0000_0004, 32'h0000_0004, 32'h8000_0000, 32'h8000_0000);
        send_fields(3'd1, 32'h0000_0006, 32'hFFFF_FFF6, 32'h0, 32'hFFFF_FFFF);
        send_fields(3'd4, 32'h0000_0004, 32'hFFFF_FFF4, 32'h0, 32'hFFFF_FFFF);
        send_fields(3'd0, 32'h0000_0000, 32'hFFFF_FF04, 32'h1234_0000, 32'hFFFF_FFFF);
        send_fields(3'd5, 32'h0000_0000, 32'hFFFF_FFFF, U32_ALL, U32_ALL);

        for (int ph = 0; ph < 3; ph++)
        begin
            sender_idle_pct = phase_idle_pct[ph];
            repeat (340)
                send_item(make_bar());
        end
        start <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule

// File: pci_bar_probe_decode_unit.f
hdl/bpd_pkg.sv
hdl/bpd_decode.sv
hdl/bpd_size.sv
hdl/bpd_check.sv
hdl/pci_bar_probe_decode_unit.sv
sim/bar_decode_checker.sv
sim/testbench.sv
